@@ src/lightmap_texel_combine_pack_assert.svh @@
// assertion macros shared by the light-map combine block
`ifndef LIGHTMAP_TEXEL_COMBINE_PACK_ASSERT_SVH
`define LIGHTMAP_TEXEL_COMBINE_PACK_ASSERT_SVH

`ifndef SYNTHESIS
// plain property checked on every edge outside reset
`define LTCP_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("%m: check failed");
// implication checked on every edge outside reset
`define LTCP_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: check failed");
`else
`define LTCP_ASSERT(label, prop)
`define LTCP_ASSERT_IMPL(label, ante, cons)
`endif

`endif

@@ src/lmtc_pkg.sv @@
package lmtc_pkg;

  // fixed-point layout
  localparam int SCALE_FRAC_BITS = 8;
  localparam int SAMPLE_W        = 8;
  localparam int SCALE_W         = 16;
  localparam int ACC_W           = 32;
  localparam int PROD_W          = SAMPLE_W + 1 + SCALE_W;
  localparam int INT_W           = ACC_W - 1 - SCALE_FRAC_BITS;
  localparam int CH_W            = 8;
  localparam int NUM_W           = INT_W + CH_W;

  // texel queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  // rescale divider, one quotient bit per cycle
  localparam int DIV_STEPS = CH_W;
  localparam int DIV_CNT_W = 3;

  // channel constants
  localparam logic [CH_W-1:0] CH_MAX = 8'd255;
  localparam int SUM_W       = 10;
  localparam int THIRD_W     = 20;
  localparam logic [SUM_W-1:0] THIRD_RECIP = 10'd683;
  localparam int THIRD_SHIFT = 11;
  localparam int MIX_W       = 2 * CH_W;

  typedef enum logic [1:0] {
    MODE_COLOUR    = 2'd0,
    MODE_ALPHA_RED = 2'd1,
    MODE_FAKED     = 2'd2,
    MODE_INV_ALPHA = 2'd3
  } mono_mode_t;

  typedef struct packed {
    logic [INT_W-1:0] red;
    logic [INT_W-1:0] green;
    logic [INT_W-1:0] blue;
  } texel_t;

  typedef struct packed {
    logic   valid;
    texel_t texel;
  } push_req_t;

  typedef struct packed {
    logic              empty;
    logic [QCNT_W-1:0] count;
  } queue_stat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAX,
    ST_DIV,
    ST_MIX,
    ST_MUL,
    ST_SCL,
    ST_OUT
  } back_state_t;

endpackage

@@ src/lightmap_texel_combine_pack.sv @@
// channel   direction  handshake              payload
// in_*      in         in_valid / in_ready    one light-map contribution
// out_*     out        out_valid / out_ready  one packed RGBA texel
// cfg_*     in         cfg_wr_en              mono mode, 2 bits
//
// front: one contribution per cycle while in_ready, product register then saturating add
// back per texel: idle, max, mix, out; divide states if the brightest channel
//   is above 255 (8-step divider), multiply and /255 states in faked color mode
// a 4-entry texel queue lets the front run ahead while the back is busy
// rst_n clears the accumulators, the queue and the mode register
module lightmap_texel_combine_pack (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [lmtc_pkg::SAMPLE_W-1:0]       in_sample_red,
  input  logic [lmtc_pkg::SAMPLE_W-1:0]       in_sample_green,
  input  logic [lmtc_pkg::SAMPLE_W-1:0]       in_sample_blue,
  input  logic signed [lmtc_pkg::SCALE_W-1:0] in_scale_red,
  input  logic signed [lmtc_pkg::SCALE_W-1:0] in_scale_green,
  input  logic signed [lmtc_pkg::SCALE_W-1:0] in_scale_blue,
  input  logic                                in_first_of_texel,
  input  logic                                in_last_of_texel,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [lmtc_pkg::CH_W-1:0]           out_red,
  output logic [lmtc_pkg::CH_W-1:0]           out_green,
  output logic [lmtc_pkg::CH_W-1:0]           out_blue,
  output logic [lmtc_pkg::CH_W-1:0]           out_alpha,
  input  logic                                cfg_wr_en,
  input  logic [1:0]                          cfg_wr_data
);
  import lmtc_pkg::*;

  mono_mode_t  mode_r;
  push_req_t   push;
  texel_t      head;
  queue_stat_t q_stat;
  logic        pop;

  // mode register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_COLOUR;
    end else if (cfg_wr_en) begin
      mode_r <= mono_mode_t'(cfg_wr_data);
    end
  end

  // accumulate front
  lmtc_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_sample_red     (in_sample_red),
    .in_sample_green   (in_sample_green),
    .in_sample_blue    (in_sample_blue),
    .in_scale_red      (in_scale_red),
    .in_scale_green    (in_scale_green),
    .in_scale_blue     (in_scale_blue),
    .in_first_of_texel (in_first_of_texel),
    .in_last_of_texel  (in_last_of_texel),
    .q_stat            (q_stat),
    .push              (push)
  );

  // finished texel queue
  lmtc_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (pop),
    .head  (head),
    .stat  (q_stat)
  );

  // rescale and pack back
  lmtc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .mono_mode (mode_r),
    .head      (head),
    .q_empty   (q_stat.empty),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_red   (out_red),
    .out_green (out_green),
    .out_blue  (out_blue),
    .out_alpha (out_alpha)
  );

endmodule

@@ src/lmtc_front.sv @@
module lmtc_front (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [lmtc_pkg::SAMPLE_W-1:0]          in_sample_red,
  input  logic [lmtc_pkg::SAMPLE_W-1:0]          in_sample_green,
  input  logic [lmtc_pkg::SAMPLE_W-1:0]          in_sample_blue,
  input  logic signed [lmtc_pkg::SCALE_W-1:0]    in_scale_red,
  input  logic signed [lmtc_pkg::SCALE_W-1:0]    in_scale_green,
  input  logic signed [lmtc_pkg::SCALE_W-1:0]    in_scale_blue,
  input  logic                                   in_first_of_texel,
  input  logic                                   in_last_of_texel,
  input  lmtc_pkg::queue_stat_t                  q_stat,
  output lmtc_pkg::push_req_t                    push
);
  import lmtc_pkg::*;

  logic                     s1_valid_r;
  logic                     s1_first_r;
  logic                     s1_last_r;
  logic signed [PROD_W-1:0] s1_prod_r [3];
  logic signed [ACC_W-1:0]  acc_r     [3];
  logic signed [ACC_W-1:0]  acc_nxt   [3];
  logic [SAMPLE_W-1:0]      sample    [3];
  logic signed [SCALE_W-1:0] scale    [3];
  logic signed [PROD_W-1:0] prod_nxt  [3];
  logic signed [ACC_W:0]    sum       [3];
  logic signed [ACC_W-1:0]  base      [3];
  logic                     accept;

  // room check counts a last contribution still in the product stage
  assign in_ready = (q_stat.count + QCNT_W'(s1_valid_r && s1_last_r)) < QCNT_W'(QUEUE_DEPTH);
  assign accept   = in_valid && in_ready;

  // per-channel products
  always_comb begin
    sample[0] = in_sample_red;
    sample[1] = in_sample_green;
    sample[2] = in_sample_blue;
    scale[0]  = in_scale_red;
    scale[1]  = in_scale_green;
    scale[2]  = in_scale_blue;
    for (int i = 0; i < 3; i++) begin
      prod_nxt[i] = PROD_W'($signed({1'b0, sample[i]})) * PROD_W'(scale[i]);
    end
  end

  // saturating accumulate
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      base[i] = s1_first_r ? '0 : acc_r[i];
      sum[i]  = (ACC_W+1)'(base[i]) + (ACC_W+1)'(s1_prod_r[i]);
      if (sum[i][ACC_W] != sum[i][ACC_W-1]) begin
        acc_nxt[i] = sum[i][ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
      end else begin
        acc_nxt[i] = sum[i][ACC_W-1:0];
      end
    end
  end

  // finished texel: drop fraction, clamp negatives
  always_comb begin
    push.valid       = s1_valid_r && s1_last_r;
    push.texel.red   = acc_nxt[0][ACC_W-1] ? '0 : acc_nxt[0][ACC_W-2:SCALE_FRAC_BITS];
    push.texel.green = acc_nxt[1][ACC_W-1] ? '0 : acc_nxt[1][ACC_W-2:SCALE_FRAC_BITS];
    push.texel.blue  = acc_nxt[2][ACC_W-1] ? '0 : acc_nxt[2][ACC_W-2:SCALE_FRAC_BITS];
  end

  // product stage control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept;
    end
  end

  // product stage payload
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_first_r <= in_first_of_texel;
      s1_last_r  <= in_last_of_texel;
      for (int i = 0; i < 3; i++) begin
        s1_prod_r[i] <= prod_nxt[i];
      end
    end
  end

  // accumulators
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        acc_r[i] <= '0;
      end
    end else if (s1_valid_r) begin
      for (int i = 0; i < 3; i++) begin
        acc_r[i] <= acc_nxt[i];
      end
    end
  end

endmodule

@@ src/lmtc_queue.sv @@
`include "lightmap_texel_combine_pack_assert.svh"

module lmtc_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  lmtc_pkg::push_req_t   push,
  input  logic                  pop,
  output lmtc_pkg::texel_t      head,
  output lmtc_pkg::queue_stat_t stat
);
  import lmtc_pkg::*;

  texel_t            mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] count_r;

  assign head       = mem_r[rd_ptr_r];
  assign stat.count = count_r;
  assign stat.empty = (count_r == '0);

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push.valid) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push.valid && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push.valid) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push.valid) begin
      mem_r[wr_ptr_r] <= push.texel;
    end
  end

  `LTCP_ASSERT_IMPL(a_no_overflow, push.valid && !pop, count_r != QCNT_W'(QUEUE_DEPTH))
  `LTCP_ASSERT_IMPL(a_no_underflow, pop, count_r != '0)
  `LTCP_ASSERT(a_count_range, count_r <= QCNT_W'(QUEUE_DEPTH))

endmodule

@@ src/lmtc_back.sv @@
module lmtc_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  lmtc_pkg::mono_mode_t       mono_mode,
  input  lmtc_pkg::texel_t           head,
  input  logic                       q_empty,
  output logic                       pop,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [lmtc_pkg::CH_W-1:0]  out_red,
  output logic [lmtc_pkg::CH_W-1:0]  out_green,
  output logic [lmtc_pkg::CH_W-1:0]  out_blue,
  output logic [lmtc_pkg::CH_W-1:0]  out_alpha
);
  import lmtc_pkg::*;

  back_state_t          state_r;
  back_state_t          state_nxt;
  logic [INT_W-1:0]     int_r   [3];
  logic [INT_W-1:0]     rem_r   [3];
  logic [CH_W-1:0]      lo_r    [3];
  logic [CH_W-1:0]      ch_r    [3];
  logic [MIX_W-1:0]     prod_r  [3];
  logic [INT_W-1:0]     m_r;
  logic [CH_W-1:0]      alpha_r;
  logic [CH_W-1:0]      a2_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 out_valid_r;
  logic [CH_W-1:0]      out_red_r;
  logic [CH_W-1:0]      out_green_r;
  logic [CH_W-1:0]      out_blue_r;
  logic [CH_W-1:0]      out_alpha_r;

  logic [INT_W-1:0]     max_val;
  logic                 over;
  logic [NUM_W-1:0]     num     [3];
  logic [INT_W:0]       trial   [3];
  logic [INT_W+1:0]     diff    [3];
  logic                 ge      [3];
  logic [SUM_W-1:0]     ch_sum;
  logic [THIRD_W-1:0]   third;
  logic [MIX_W:0]       scl     [3];
  logic                 div_done;
  logic                 out_free;
  logic                 out_load;

  assign out_valid = out_valid_r;
  assign out_red   = out_red_r;
  assign out_green = out_green_r;
  assign out_blue  = out_blue_r;
  assign out_alpha = out_alpha_r;
  assign out_free  = !out_valid_r || out_ready;
  assign div_done  = (cnt_r == DIV_CNT_W'(DIV_STEPS - 1));

  // brightest channel and rescale numerators c*255
  always_comb begin
    max_val = (int_r[0] > int_r[1]) ? int_r[0] : int_r[1];
    if (int_r[2] > max_val) begin
      max_val = int_r[2];
    end
    over = (max_val > INT_W'(CH_MAX));
    for (int i = 0; i < 3; i++) begin
      num[i] = {int_r[i], {CH_W{1'b0}}} - NUM_W'(int_r[i]);
    end
  end

  // one restoring divide step per lane
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      trial[i] = {rem_r[i], lo_r[i][CH_W-1]};
      diff[i]  = {1'b0, trial[i]} - {2'b00, m_r};
      ge[i]    = !diff[i][INT_W+1];
    end
  end

  // faked color: alpha is 255 minus the channel mean, then scale by alpha/255
  always_comb begin
    ch_sum = SUM_W'(ch_r[0]) + SUM_W'(ch_r[1]) + SUM_W'(ch_r[2]);
    third  = THIRD_W'(ch_sum) * THIRD_W'(THIRD_RECIP);
    for (int i = 0; i < 3; i++) begin
      scl[i] = (MIX_W+1)'(prod_r[i]) + (MIX_W+1)'(prod_r[i][MIX_W-1:CH_W]) + 1'b1;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (!q_empty) state_nxt = ST_MAX;
      ST_MAX:  state_nxt = over ? ST_DIV : ST_MIX;
      ST_DIV:  if (div_done) state_nxt = ST_MIX;
      ST_MIX:  state_nxt = (mono_mode == MODE_FAKED) ? ST_MUL : ST_OUT;
      ST_MUL:  state_nxt = ST_SCL;
      ST_SCL:  state_nxt = ST_OUT;
      ST_OUT:  if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    pop      = 1'b0;
    out_load = 1'b0;
    case (state_r)
      ST_IDLE: pop = !q_empty;
      ST_OUT:  out_load = out_free;
      default: begin
        pop      = 1'b0;
        out_load = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        int_r[0] <= head.red;
        int_r[1] <= head.green;
        int_r[2] <= head.blue;
      end
      ST_MAX: begin
        m_r     <= max_val;
        cnt_r   <= '0;
        alpha_r <= over ? CH_MAX : max_val[CH_W-1:0];
        for (int i = 0; i < 3; i++) begin
          rem_r[i] <= num[i][NUM_W-1:CH_W];
          lo_r[i]  <= num[i][CH_W-1:0];
          ch_r[i]  <= int_r[i][CH_W-1:0];
        end
      end
      ST_DIV: begin
        cnt_r <= cnt_r + 1'b1;
        for (int i = 0; i < 3; i++) begin
          rem_r[i] <= ge[i] ? diff[i][INT_W-1:0] : trial[i][INT_W-1:0];
          lo_r[i]  <= {lo_r[i][CH_W-2:0], 1'b0};
          ch_r[i]  <= {ch_r[i][CH_W-2:0], ge[i]};
        end
      end
      ST_MIX: begin
        a2_r <= CH_MAX - third[THIRD_SHIFT+CH_W-1:THIRD_SHIFT];
      end
      ST_MUL: begin
        for (int i = 0; i < 3; i++) begin
          prod_r[i] <= MIX_W'(ch_r[i]) * MIX_W'(a2_r);
        end
      end
      ST_SCL: begin
        alpha_r <= a2_r;
        for (int i = 0; i < 3; i++) begin
          ch_r[i] <= scl[i][MIX_W-1:CH_W];
        end
      end
      ST_OUT: begin
        if (out_load) begin
          case (mono_mode)
            MODE_ALPHA_RED: begin
              out_red_r   <= alpha_r;
              out_green_r <= '0;
              out_blue_r  <= '0;
              out_alpha_r <= alpha_r;
            end
            MODE_INV_ALPHA: begin
              out_red_r   <= '0;
              out_green_r <= '0;
              out_blue_r  <= '0;
              out_alpha_r <= CH_MAX - alpha_r;
            end
            default: begin
              out_red_r   <= ch_r[0];
              out_green_r <= ch_r[1];
              out_blue_r  <= ch_r[2];
              out_alpha_r <= alpha_r;
            end
          endcase
        end
      end
      default: begin
        cnt_r <= cnt_r;
      end
    endcase
  end

endmodule
